FILE: sv/sxde_pkg.sv
// Shared types and constants for the sprite XOR draw engine.
package sxde_pkg;

  // Command codes carried in the request item
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Frame row width and the left-justify shift of a sprite byte
  localparam int unsigned ROW_BITS   = 64;
  localparam int unsigned BYTE_SHIFT = 56;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] x_coord;
    logic [7:0] y_coord;
    logic [3:0] row_index;
    logic       last_row;
    logic [7:0] sprite_byte;
    logic [4:0] row_select;
  } req_t;

  typedef struct packed {
    logic        collision;
    logic        row_drawn;
    logic [63:0] row_bits;
    logic        sprite_done;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the accepted item
    logic rd_en;   // resolve the row address and read the frame row
    logic commit;  // update frame and flag, load the result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic rsp_free;  // result register can take a new item this cycle
  } dp_status_t;

endpackage

FILE: sv/sxde_ctrl.sv
// Sequencer for one item: accept, address and read, modify and commit.
module sxde_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  sxde_pkg::dp_status_t status,
  output sxde_pkg::dp_cmd_t    cmd
);
  import sxde_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_ADDR   = 3'b010,
    ST_MODIFY = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Step through the phases; hold in modify until the result slot frees
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_ADDR;
      end
      ST_ADDR: begin
        state_next = ST_MODIFY;
      end
      ST_MODIFY: begin
        if (status.rsp_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Drive the handshake and the datapath commands
  assign req_ready  = (state == ST_IDLE);
  assign cmd.load   = req_valid && (state == ST_IDLE);
  assign cmd.rd_en  = (state == ST_ADDR);
  assign cmd.commit = (state == ST_MODIFY) && status.rsp_free;

endmodule

FILE: sv/sxde_datapath.sv
// Frame memory, sprite placement, collision flag and result register.
module sxde_datapath #(
  parameter int unsigned SCREEN_ROWS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sxde_pkg::req_t       req_item,
  input  logic                 cfg_valid,
  input  logic                 cfg_data,
  input  sxde_pkg::dp_cmd_t    cmd,
  output sxde_pkg::dp_status_t status,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output sxde_pkg::rsp_t       rsp_item
);
  import sxde_pkg::*;

  localparam int unsigned AW    = $clog2(SCREEN_ROWS);
  // Reciprocal for y mod SCREEN_ROWS: exact quotient for 8-bit y
  localparam int unsigned RECIP = (65536 + SCREEN_ROWS - 1) / SCREEN_ROWS;
  localparam logic [8:0]  ROWS9 = 9'(SCREEN_ROWS);

  // Place a sprite byte MSB-first at a column, clipped or wrapped
  function automatic logic [ROW_BITS-1:0] place_byte(
    input logic [7:0] byte_val,
    input logic [5:0] col,
    input logic       clip
  );
    logic [ROW_BITS-1:0] v;
    logic [6:0]          back;
    begin
      v    = {byte_val, {BYTE_SHIFT{1'b0}}};
      back = 7'(ROW_BITS) - {1'b0, col};
      if (clip || col == 6'd0) begin
        place_byte = v >> col;
      end else begin
        place_byte = (v >> col) | (v << back);
      end
    end
  endfunction

  req_t                 item;
  logic [7:0]           quot;
  logic                 clip_en;
  logic                 coll_flag;
  logic [AW-1:0]        row_addr;
  logic [AW-1:0]        rd_addr;
  logic                 row_ok;
  logic [ROW_BITS-1:0]  rd_data;
  logic [ROW_BITS-1:0]  frame_mem [SCREEN_ROWS];
  logic [SCREEN_ROWS-1:0] row_valid;

  logic [24:0]          prod;
  logic [15:0]          qr;
  logic [7:0]           ymod;
  logic [8:0]           row_sum;
  logic                 row_wrap;
  logic [8:0]           row_fix;
  logic [6:0]           rsel_ext;
  logic [ROW_BITS-1:0]  old_row;
  logic [ROW_BITS-1:0]  pat;
  logic [ROW_BITS-1:0]  new_row;
  logic                 coll_next;
  logic                 draw_wr;
  rsp_t                 rsp_next;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_en <= 1'b0;
    end else if (cfg_valid) begin
      clip_en <= cfg_data;
    end
  end

  // Capture the item and the quotient of y by the row count
  assign prod = 25'(req_item.y_coord) * 25'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req_item;
      quot <= prod[23:16];
    end
  end

  // Resolve the target row: wrap or clip past the bottom edge
  assign qr       = 16'(quot) * 16'(SCREEN_ROWS);
  assign ymod     = item.y_coord - qr[7:0];
  assign row_sum  = {1'b0, ymod} + 9'(item.row_index);
  assign row_wrap = row_sum >= ROWS9;
  assign row_fix  = row_wrap ? row_sum - ROWS9 : row_sum;
  assign rsel_ext = 7'(item.row_select);
  assign rd_addr  = (item.cmd == CMD_READ) ? rsel_ext[AW-1:0] : row_fix[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      if (item.cmd == CMD_READ) begin
        row_addr <= rsel_ext[AW-1:0];
        row_ok   <= 32'(rsel_ext) < SCREEN_ROWS;
      end else begin
        row_addr <= row_fix[AW-1:0];
        row_ok   <= !(row_wrap && clip_en);
      end
    end
  end

  // Frame memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= frame_mem[rd_addr];
    end
    if (draw_wr) begin
      frame_mem[row_addr] <= new_row;
    end
  end

  // Valid bits: an unwritten or cleared row reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.commit && item.cmd == CMD_CLEAR) begin
      row_valid <= '0;
    end else if (draw_wr) begin
      row_valid[row_addr] <= 1'b1;
    end
  end

  // XOR the sprite row in and test for erased pixels
  assign old_row   = row_valid[row_addr] ? rd_data : '0;
  assign pat       = place_byte(item.sprite_byte, item.x_coord[5:0], clip_en);
  assign new_row   = old_row ^ pat;
  assign coll_next = ((item.row_index != 4'd0) && coll_flag)
                     || (row_ok && ((old_row & pat) != '0));
  assign draw_wr   = cmd.commit && (item.cmd == CMD_DRAW) && row_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      coll_flag <= 1'b0;
    end else if (cmd.commit && item.cmd == CMD_DRAW) begin
      coll_flag <= coll_next;
    end
  end

  // Form the result for each command
  always_comb begin
    rsp_next = '0;
    unique case (item.cmd)
      CMD_DRAW: begin
        rsp_next.collision   = coll_next;
        rsp_next.row_drawn   = row_ok;
        rsp_next.row_bits    = row_ok ? new_row : '0;
        rsp_next.sprite_done = item.last_row;
      end
      CMD_READ: begin
        rsp_next.row_bits = row_ok ? old_row : '0;
      end
      default: rsp_next = '0;
    endcase
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_item <= rsp_next;
    end
  end

  assign status.rsp_free = !rsp_valid || rsp_ready;

endmodule

FILE: sv/sprite_xor_draw_engine.sv
// Top level of the sprite XOR draw engine: controller plus datapath.
//
// Holds a 64-column frame of SCREEN_ROWS rows and executes one command per
// request item: clear the frame, XOR one sprite row into it, or read a row.
// Request channel req_valid/req_ready carries req_item; every item yields
// exactly one result item on rsp_valid/rsp_ready.
// Configuration: cfg_valid/cfg_ready writes clip_enable from cfg_data; it is
// always ready and must only be written while the engine is idle.
// An accepted item passes the ADDR and MODIFY states and then has its result in
// the output register when that register is free. No new item is taken until
// the last is committed; the frame memory's read-modify-write resolves the row
// and reads it in ADDR, then XORs, writes back and loads the result in MODIFY.
// A clear resets the valid bits at commit, so no clearing sweep is needed.
// Reset clears the frame (all rows read zero), the collision flag and
// clip_enable, and empties the result register.
// When the receiver stalls, the result waits in the output register and the
// engine may already accept and resolve the next item, holding it before
// commit until the register is taken.
module sprite_xor_draw_engine #(
  parameter int unsigned SCREEN_ROWS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  sxde_pkg::req_t req_item,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output sxde_pkg::rsp_t rsp_item,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data
);
  import sxde_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  assign cfg_ready = 1'b1;

  sxde_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  sxde_datapath #(
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_item  (req_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (dp_cmd),
    .status    (dp_status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item)
  );

endmodule

FILE: sv/sxde_checker.sv
// Port-level checks for the sprite XOR draw engine, bound to the top level.
module sxde_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input sxde_pkg::rsp_t rsp_item
);
  import sxde_pkg::*;

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // An accepted item keeps the engine from taking another through ADDR and MODIFY
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready ##1 !req_ready)
    else $error("engine took a new item too early");

  // A fresh result follows a cycle in which the engine was busy
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("result appeared without an item in progress");

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_item)))
    else $error("stalled result dropped or changed");

endmodule

bind sprite_xor_draw_engine sxde_checker u_sxde_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_item  (rsp_item)
);

FILE: test/sprite_frame_checker.sv
// Checker for the sprite XOR draw engine: frame predictor and result comparison.
module sprite_frame_checker #(
  parameter int unsigned SCREEN_ROWS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  sxde_pkg::req_t req_item,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  sxde_pkg::rsp_t rsp_item,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic           cfg_data,
  input  logic           run_over,
  output int unsigned    results_owed,
  output int unsigned    mismatches
);
  timeunit 1ns;
  timeprecision 1ps;
  import sxde_pkg::*;

  // Predicted engine state
  logic [ROW_BITS-1:0] frame_rows [SCREEN_ROWS];
  logic                erased_flag;
  logic                clip_on;
  rsp_t                frame_results_due [$];
  rsp_t                predicted;
  logic                leftovers_checked;

  // Apply one item to the predicted frame and return the result it should give
  function automatic rsp_t predict_frame_op(input req_t r);
    rsp_t                o;
    int unsigned         col;
    int unsigned         row;
    logic                on_screen;
    logic [ROW_BITS-1:0] placed;
    logic [ROW_BITS-1:0] pattern;
    o = '0;
    case (r.cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < SCREEN_ROWS; i++) frame_rows[i] = '0;
      end
      CMD_DRAW: begin
        col = r.x_coord % ROW_BITS;
        row = (r.y_coord % SCREEN_ROWS) + r.row_index;
        on_screen = 1'b1;
        // a sprite's first row starts a fresh collision test
        if (r.row_index == 4'd0) erased_flag = 1'b0;
        if (row >= SCREEN_ROWS) begin
          if (clip_on) on_screen = 1'b0;
          else row = row % SCREEN_ROWS;
        end
        if (on_screen) begin
          placed = ROW_BITS'(r.sprite_byte) << BYTE_SHIFT;
          pattern = placed >> col;
          // wrap the spill past column 63 back to the left edge
          if (!clip_on && col != 0) pattern = pattern | (placed << (ROW_BITS - col));
          if ((frame_rows[row] & pattern) != '0) erased_flag = 1'b1;
          frame_rows[row] = frame_rows[row] ^ pattern;
          o.row_bits = frame_rows[row];
          o.row_drawn = 1'b1;
        end
        o.collision = erased_flag;
        o.sprite_done = r.last_row;
      end
      CMD_READ: begin
        if (r.row_select < SCREEN_ROWS) o.row_bits = frame_rows[r.row_select];
      end
      default: begin
        // unused code: nothing changes, all-zero result
      end
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns mismatch: %s", $time, what);
  endtask

  // Compare one taken result with the oldest prediction
  task automatic compare_result(input rsp_t got);
    rsp_t want;
    if (frame_results_due.size() == 0) begin
      report_mismatch($sformatf("result with nothing due, row_bits %h", got.row_bits));
      return;
    end
    want = frame_results_due.pop_front();
    if (got.collision !== want.collision)
      report_mismatch($sformatf("collision %b, predicted %b", got.collision, want.collision));
    if (got.row_drawn !== want.row_drawn)
      report_mismatch($sformatf("row_drawn %b, predicted %b", got.row_drawn, want.row_drawn));
    if (got.row_bits !== want.row_bits)
      report_mismatch($sformatf("row_bits %h, predicted %h", got.row_bits, want.row_bits));
    if (got.sprite_done !== want.sprite_done)
      report_mismatch($sformatf("sprite_done %b, predicted %b",
                                got.sprite_done, want.sprite_done));
  endtask

  // Watch the channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SCREEN_ROWS; i++) frame_rows[i] = '0;
      erased_flag = 1'b0;
      clip_on = 1'b0;
      frame_results_due.delete();
      leftovers_checked = 1'b0;
      mismatches = 0;
      results_owed <= 0;
    end else begin
      if (cfg_valid && cfg_ready) clip_on = cfg_data;
      // queue the prediction behind the older ones
      if (req_valid && req_ready) begin
        predicted = predict_frame_op(req_item);
        frame_results_due = {frame_results_due, predicted};
      end
      if (rsp_valid && rsp_ready) compare_result(rsp_item);
      results_owed <= frame_results_due.size();
      if (run_over && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (frame_results_due.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", frame_results_due.size()));
      end
    end
  end

endmodule

FILE: test/tb.sv
// Top of the sprite XOR draw engine testbench: stimulus, receiver pacing and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sxde_pkg::*;

  localparam int unsigned SCREEN_ROWS = 32;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 120;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_CADENCE, RX_SLUGGISH} rx_mode_e;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req_item;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        run_over;
  int unsigned results_owed;
  int unsigned mismatches;

  int unsigned burst_left;
  int unsigned items_sent;
  int unsigned idle_cycles;
  int unsigned rx_holds_asked;
  int unsigned rx_holds_done;
  int unsigned rx_hold_left;
  int unsigned rx_mode_left;
  int unsigned rx_phase;
  rx_mode_e    rx_mode;

  // Single configuration register, clip_enable, written through the cfg port
  sprite_xor_draw_engine #(.SCREEN_ROWS(SCREEN_ROWS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  sprite_frame_checker #(.SCREEN_ROWS(SCREEN_ROWS)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req_item     (req_item),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp_item     (rsp_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .run_over     (run_over),
    .results_owed (results_owed),
    .mismatches   (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Pace the receiver: changing stall patterns plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rx_hold_left = 0;
      rx_holds_done = 0;
      rx_mode_left = 0;
      rx_phase = 0;
    end else begin
      if (rx_hold_left == 0 && rx_holds_done != rx_holds_asked) begin
        rx_holds_done = rx_holds_asked;
        rx_hold_left = HOLD_CYCLES;
      end
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(50, 300);
      end
      rx_mode_left--;
      rx_phase++;
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_STEADY:   rsp_ready <= 1'b1;
          RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
          RX_CADENCE:  rsp_ready <= (rx_phase % 4) != 3;
          RX_SLUGGISH: rsp_ready <= $urandom_range(0, 7) == 0;
          default:     rsp_ready <= 1'b1;
        endcase
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic req_t mk_draw(input logic [7:0] x, input logic [7:0] y,
                                   input logic [3:0] ridx, input logic last,
                                   input logic [7:0] pixels);
    req_t r;
    r = '0;
    r.cmd = CMD_DRAW;
    r.x_coord = x;
    r.y_coord = y;
    r.row_index = ridx;
    r.last_row = last;
    r.sprite_byte = pixels;
    r.row_select = 5'($urandom);
    return r;
  endfunction

  // Command with random filler in the fields it does not use
  function automatic req_t mk_cmd(input logic [1:0] code, input logic [4:0] rsel);
    logic [63:0] raw;
    req_t        r;
    raw = {$urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    r.cmd = code;
    r.row_select = rsel;
    return r;
  endfunction

  // Offer one item, with bursts and gaps; returns at the edge that takes it
  task automatic offer_item(input req_t r);
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    req_valid <= 1'b1;
    req_item <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    items_sent++;
  endtask

  // Hold the sender until every predicted result has been taken
  task automatic wait_drained();
    req_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic write_clip(input logic enable);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= enable;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One well-formed sprite of random shape, now and then with a read in between
  task automatic offer_sprite();
    int unsigned rows;
    logic [7:0]  x;
    logic [7:0]  y;
    rows = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
    x = 8'($urandom);
    y = 8'($urandom);
    for (int i = 0; i < rows; i++) begin
      if ($urandom_range(0, 9) == 0) offer_item(mk_cmd(CMD_READ, 5'($urandom)));
      offer_item(mk_draw(x, y, 4'(i), i == rows - 1, 8'($urandom)));
    end
  endtask

  task automatic random_phase(input int unsigned quota, input logic with_hold);
    int unsigned first;
    int unsigned pick;
    logic [63:0] raw;
    first = items_sent;
    if (with_hold) rx_holds_asked <= rx_holds_asked + 1;
    while (items_sent - first < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) offer_sprite();
      else if (pick < 82) offer_item(mk_cmd(CMD_READ, 5'($urandom)));
      else if (pick < 84) offer_item(mk_cmd(CMD_CLEAR, 5'($urandom)));
      else if (pick < 86) offer_item(mk_cmd(CMD_UNUSED, 5'($urandom)));
      else begin
        // broken or arbitrary item
        raw = {$urandom, $urandom};
        offer_item(raw[$bits(req_t)-1:0]);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req_item = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    run_over = 1'b0;
    burst_left = 0;
    items_sent = 0;
    rx_holds_asked = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Wrapping: collisions, edge wrap of columns and rows, odd commands
    write_clip(1'b0);
    offer_item(mk_cmd(CMD_READ, 5'd0));
    offer_item(mk_draw(8'd0, 8'd0, 4'd0, 1'b0, 8'hFF));
    offer_item(mk_draw(8'd0, 8'd0, 4'd1, 1'b1, 8'h3C));
    offer_item(mk_draw(8'd0, 8'd0, 4'd0, 1'b0, 8'hFF));
    offer_item(mk_draw(8'd0, 8'd0, 4'd1, 1'b1, 8'h3C));
    offer_item(mk_draw(8'd63, 8'd31, 4'd1, 1'b0, 8'hC3));
    offer_item(mk_draw(8'd255, 8'd255, 4'd15, 1'b1, 8'hFF));
    offer_item(mk_draw(8'd100, 8'd7, 4'd0, 1'b1, 8'h00));
    offer_item(mk_cmd(CMD_READ, 5'd0));
    offer_item(mk_cmd(CMD_READ, 5'd14));
    offer_item(mk_cmd(CMD_READ, 5'd31));
    offer_item(mk_cmd(CMD_UNUSED, 5'd31));
    offer_item(mk_cmd(CMD_CLEAR, 5'd0));
    offer_item(mk_cmd(CMD_READ, 5'd14));

    // Clipping: right edge, bottom edge, flag kept across a clipped row
    write_clip(1'b1);
    offer_item(mk_draw(8'd60, 8'd5, 4'd0, 1'b0, 8'hFF));
    offer_item(mk_draw(8'd60, 8'd5, 4'd0, 1'b1, 8'hF0));
    offer_item(mk_draw(8'd0, 8'd31, 4'd0, 1'b0, 8'h81));
    offer_item(mk_draw(8'd0, 8'd63, 4'd0, 1'b0, 8'h81));
    offer_item(mk_draw(8'd0, 8'd31, 4'd1, 1'b1, 8'hFF));
    offer_item(mk_draw(8'd72, 8'd63, 4'd0, 1'b0, 8'h81));
    offer_item(mk_draw(8'd199, 8'd17, 4'd15, 1'b1, 8'hAA));
    offer_item(mk_cmd(CMD_READ, 5'd31));

    // Random phases across both settings
    write_clip(1'b0);
    random_phase(350, 1'b1);
    write_clip(1'b1);
    random_phase(350, 1'b0);
    write_clip(1'b0);
    random_phase(300, 1'b0);
    write_clip(1'b1);
    random_phase(350, 1'b1);
    write_clip(1'b0);
    random_phase(300, 1'b0);

    // Drain, let stragglers show, then judge
    wait_drained();
    repeat (8) @(posedge clk);
    run_over <= 1'b1;
    repeat (3) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
